// ===== src/mdinv_pkg.sv =====
// ---------------------------------------------------------------------------
// mdinv_pkg: shared types and constants for the modular inverse unit
// Operand width, controller states and the result bundle passed to the top.
// ---------------------------------------------------------------------------
package mdinv_pkg;

    localparam int WIDTH   = 32;
    localparam int K_WIDTH = $clog2(WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ALIGN,
        ST_SUB,
        ST_SWAP,
        ST_FIX,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [WIDTH-1:0] inverse;
        logic             found;
    } t_result;

endpackage

// ===== src/modular_inverse_unit.sv =====
// ---------------------------------------------------------------------------
// modular_inverse_unit: modular inverse by extended Euclid
// Stream wrapper around the serial Euclid engine with a result register.
// ---------------------------------------------------------------------------
// One word at a time. Each Euclid step (plus one reducing step) aligns the
// divisor, then the shift-and-subtract divider yields one quotient bit per
// cycle, then the remainders swap. A new word is taken once the engine is
// idle; a finished result waits in the output register. found is 0 and
// inverse 0 when the gcd is not one.
module modular_inverse_unit
    import mdinv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [2*WIDTH-1:0]     s_axis_tdata,  // value, modulus
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [WIDTH-1:0]       m_axis_tdata,  // inverse
    output logic                   m_axis_tuser   // found
);

    logic    r_ovalid;
    t_result r_out;
    logic    w_idle, w_done, w_ack, w_start;
    t_result w_res;

    assign w_start = s_axis_tvalid && w_idle;
    assign w_ack   = w_done && (!r_ovalid || m_axis_tready);

    mdinv_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_value   (s_axis_tdata[WIDTH-1:0]),
        .i_modulus (s_axis_tdata[2*WIDTH-1:WIDTH]),
        .i_ack     (w_ack),
        .o_idle    (w_idle),
        .o_done    (w_done),
        .o_result  (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_ack) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_out <= w_res;
        end
    end

    assign s_axis_tready = w_idle;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out.inverse;
    assign m_axis_tuser  = r_out.found;

endmodule

// ===== src/mdinv_core.sv =====
// ---------------------------------------------------------------------------
// mdinv_core: extended Euclid engine
// Each Euclid step divides by shift and subtract, one quotient bit per
// cycle, and accumulates the cofactor with the same shifted terms.
// ---------------------------------------------------------------------------
module mdinv_core
    import mdinv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_value,
    input  logic [WIDTH-1:0] i_modulus,
    input  logic             i_ack,
    output logic             o_idle,
    output logic             o_done,
    output t_result          o_result
);

    t_state             r_state, n_state;
    logic [WIDTH-1:0]   r_r0, r_r1, r_u0, r_u1, r_d, r_e, r_mod;
    logic [K_WIDTH-1:0] r_k;
    logic               r_neg0, r_neg1, r_pre;
    t_result            r_res;

    logic               w_align_go;
    logic               w_sub_ok;
    logic [WIDTH-1:0]   w_uu;

    // divisor can still double without passing the remainder
    assign w_align_go = ({r_d, 1'b0} <= {1'b0, r_r0});
    assign w_sub_ok   = (r_d <= r_r0);
    assign w_uu       = (r_u0 == r_mod) ? '0 : r_u0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_start) n_state = (i_modulus == '0) ? ST_DONE : ST_CHECK;
            ST_CHECK: n_state = (r_r1 == '0) ? ST_FIX : ST_ALIGN;
            ST_ALIGN: if (!w_align_go) n_state = ST_SUB;
            ST_SUB:   if (r_k == '0) n_state = ST_SWAP;
            ST_SWAP:  n_state = ST_CHECK;
            ST_FIX:   n_state = ST_DONE;
            ST_DONE:  if (i_ack) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_idle   = (r_state == ST_IDLE);
        o_done   = (r_state == ST_DONE);
        o_result = r_res;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                // pre-step reduces the value modulo the modulus
                r_r0   <= i_value;
                r_r1   <= i_modulus;
                r_u0   <= {{(WIDTH-1){1'b0}}, 1'b1};
                r_u1   <= '0;
                r_mod  <= i_modulus;
                r_pre  <= 1'b1;
                r_neg0 <= 1'b0;
                r_neg1 <= 1'b0;
                r_res  <= '0;
            end
            ST_CHECK: begin
                r_d <= r_r1;
                r_e <= r_u1;
                r_k <= '0;
            end
            ST_ALIGN: begin
                if (w_align_go) begin
                    r_d <= {r_d[WIDTH-2:0], 1'b0};
                    r_e <= {r_e[WIDTH-2:0], 1'b0};
                    r_k <= r_k + 1'b1;
                end
            end
            ST_SUB: begin
                if (w_sub_ok) begin
                    r_r0 <= r_r0 - r_d;
                    r_u0 <= r_u0 + r_e;
                end
                if (r_k != '0) begin
                    r_d <= {1'b0, r_d[WIDTH-1:1]};
                    r_e <= {1'b0, r_e[WIDTH-1:1]};
                    r_k <= r_k - 1'b1;
                end
            end
            ST_SWAP: begin
                r_r0 <= r_r1;
                r_r1 <= r_r0;
                r_u0 <= r_u1;
                r_u1 <= r_u0;
                if (r_pre) begin
                    r_pre  <= 1'b0;
                    r_neg0 <= 1'b0;
                    r_neg1 <= 1'b0;
                end else begin
                    r_neg0 <= r_neg1;
                    r_neg1 <= ~r_neg1;
                end
            end
            ST_FIX: begin
                r_res.found <= (r_r0 == {{(WIDTH-1){1'b0}}, 1'b1});
                if (r_r0 != {{(WIDTH-1){1'b0}}, 1'b1}) begin
                    r_res.inverse <= '0;
                end else if (r_neg0 && (w_uu != '0)) begin
                    r_res.inverse <= r_mod - w_uu;
                end else begin
                    r_res.inverse <= w_uu;
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule
